>>> hw/rtl/ucr_pkg.sv
// ----------------------------------------------------------------------------
// Unicycle trajectory rollout package
// Payload types, controller states, datapath commands and the fixed-point
// constants shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package ucr_pkg;

    // Input transaction: one motion candidate.
    typedef struct packed {
        logic signed [15:0] linear_speed;   // Q8.8 m/s
        logic signed [15:0] turn_rate;      // Q4.12 rad/s
        logic        [5:0]  horizon_ticks;  // 0.1 s ticks, zero selects default
    } t_in_item;

    // Output transaction: one trajectory point.
    typedef struct packed {
        logic signed [31:0] x_pos;          // Q16.16 m
        logic signed [31:0] y_pos;          // Q16.16 m
        logic               last_point;
    } t_out_item;

    // Widths of the horizon and the step counter, the horizon cap and the reset default horizon.
    localparam int HOR_W         = 6;
    localparam int STEP_W        = 7;
    localparam int HOR_LIMIT     = 63;
    localparam logic [HOR_W-1:0] DEF_HOR_RESET = 6'd20;

    // Arithmetic widths.
    localparam int ANG_W   = 32;   // binary angle
    localparam int CW      = 32;   // CORDIC x and y, Q2.30
    localparam int ZW      = 33;   // CORDIC residual angle
    localparam int VDT_W   = 34;   // speed times dt
    localparam int PROD_W  = VDT_W + CW;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_ENTRIES = 24;

    // 0.1 s * 2^20 / (2 pi) in Q16: maps Q4.12 rad/s over one step to binary angle.
    localparam logic signed [31:0] HEAD_K    = 32'sd1093704441;
    // 0.1 in Q20.
    localparam logic signed [17:0] DT_Q20    = 18'sd104858;
    // Reciprocal of the CORDIC gain in Q30.
    localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FOLD,
        S_ITER,
        S_MUL_X,
        S_MUL_Y,
        S_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_FOLD,
        OP_ITER,
        OP_MUL_X,
        OP_MUL_Y,
        OP_ACC,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op                  op;
        logic [ATAN_IDX_W-1:0]   iter_idx;
        logic                    last;
    } t_dp_cmd;

    // atan(2^-i) * 2^32 / (2 pi), rounded to nearest
    function automatic logic [31:0] atan_value(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/ucr_dp.sv
// ----------------------------------------------------------------------------
// Unicycle rollout datapath
// Heading and speed scaling, iterative CORDIC, position multiply and
// accumulate, and the output payload register, all driven by commands.
// ----------------------------------------------------------------------------
module ucr_dp
    import ucr_pkg::*;
(
    input  logic      i_clk,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_data,
    output t_out_item o_data
);

    logic signed [15:0]       r_v;
    logic signed [15:0]       r_w;
    logic signed [VDT_W-1:0]  r_vdt;
    logic [ANG_W-1:0]         r_dhead;
    logic [ANG_W-1:0]         r_heading;
    logic signed [CW-1:0]     r_cx;
    logic signed [CW-1:0]     r_cy;
    logic signed [ZW-1:0]     r_cz;
    logic                     r_flip;
    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]              r_x_acc;
    logic [31:0]              r_y_acc;
    t_out_item                r_out;

    logic signed [47:0]       head_prod;
    logic [ANG_W-1:0]         dhead_next;
    logic signed [VDT_W-1:0]  vdt_next;
    logic                     flip;
    logic signed [ZW-1:0]     z_fold;
    logic signed [CW-1:0]     xs;
    logic signed [CW-1:0]     ys;
    logic signed [ZW-1:0]     atan_z;
    logic signed [CW-1:0]     cos_v;
    logic signed [CW-1:0]     sin_v;
    logic signed [CW-1:0]     mul_in;
    logic signed [PROD_W-1:0] prod_next;
    logic [31:0]              inc;

    // Heading increment, rounded half up.
    assign head_prod  = r_w * HEAD_K;
    assign dhead_next = head_prod[47:16] + {31'b0, head_prod[15]};
    assign vdt_next   = r_v * DT_Q20;

    // Fold the angle into the right half plane when it points left.
    assign flip   = r_heading[31] ^ r_heading[30];
    assign z_fold = {r_heading[31] ^ flip, r_heading[31] ^ flip, r_heading[30:0]};

    assign xs     = r_cx >>> i_cmd.iter_idx;
    assign ys     = r_cy >>> i_cmd.iter_idx;
    assign atan_z = $signed({1'b0, atan_value(i_cmd.iter_idx)});

    assign cos_v     = r_flip ? -r_cx : r_cx;
    assign sin_v     = r_flip ? -r_cy : r_cy;
    assign mul_in    = (i_cmd.op == OP_MUL_X) ? cos_v : sin_v;
    assign prod_next = r_vdt * mul_in;

    // Round to nearest by adding the bit just below the cut.
    assign inc = {{8{r_prod[PROD_W-1]}}, r_prod[PROD_W-1:42]} + {31'b0, r_prod[41]};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                r_v       <= i_data.linear_speed;
                r_w       <= i_data.turn_rate;
                r_x_acc   <= '0;
                r_y_acc   <= '0;
                r_heading <= '0;
            end
            OP_PREP: begin
                r_dhead <= dhead_next;
                r_vdt   <= vdt_next;
            end
            OP_FOLD: begin
                r_cx   <= CORDIC_X0;
                r_cy   <= '0;
                r_cz   <= z_fold;
                r_flip <= flip;
            end
            OP_ITER: begin
                if (!r_cz[ZW-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_z;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_z;
                end
            end
            OP_MUL_X: begin
                r_prod <= prod_next;
            end
            OP_MUL_Y: begin
                r_x_acc <= r_x_acc + inc;
                r_prod  <= prod_next;
            end
            OP_ACC: begin
                r_y_acc   <= r_y_acc + inc;
                r_heading <= r_heading + r_dhead;
            end
            OP_EMIT: begin
                r_out.x_pos      <= r_x_acc;
                r_out.y_pos      <= r_y_acc;
                r_out.last_point <= i_cmd.last;
            end
        endcase
    end

    assign o_data = r_out;

endmodule

>>> hw/rtl/ucr_ctrl.sv
// ----------------------------------------------------------------------------
// Unicycle rollout controller
// Sequences each candidate through preparation, CORDIC iterations, position
// update and point emission; holds the default horizon and output valid.
// ----------------------------------------------------------------------------
module ucr_ctrl
    import ucr_pkg::*;
#(
    parameter int MAX_HORIZON_TICKS = 63,
    parameter int TRIG_ITERATIONS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [HOR_W-1:0] i_horizon,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [HOR_W-1:0] i_cfg_data,
    output t_dp_cmd          o_cmd
);

    localparam int IW   = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam int HCAP = (MAX_HORIZON_TICKS < HOR_LIMIT) ? MAX_HORIZON_TICKS : HOR_LIMIT;
    localparam logic [STEP_W-1:0] HCAP_V    = STEP_W'(HCAP);
    localparam logic [IW-1:0]     ITER_LAST = IW'(TRIG_ITERATIONS - 1);

    t_state              r_state;
    t_state              n_state;
    logic [IW-1:0]       r_iter;
    logic [IW-1:0]       n_iter;
    logic [STEP_W-1:0]   r_steps;
    logic [STEP_W-1:0]   n_steps;
    logic [HOR_W-1:0]    r_def_hor;
    logic                r_out_valid;
    logic                n_out_valid;

    logic                out_free;
    logic                accept;
    logic                emit;
    logic [HOR_W-1:0]    hor_raw;
    logic [STEP_W-1:0]   hor_eff;

    assign out_free = !r_out_valid || !i_stall;
    assign accept   = (r_state == S_IDLE) && i_valid;
    assign emit     = (r_state == S_EMIT) && out_free;

    assign hor_raw = (i_horizon == '0) ? r_def_hor : i_horizon;
    assign hor_eff = (STEP_W'(hor_raw) > HCAP_V) ? HCAP_V : STEP_W'(hor_raw);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PREP;
            S_PREP:  n_state = S_FOLD;
            S_FOLD:  n_state = S_ITER;
            S_ITER:  if (r_iter == ITER_LAST) n_state = S_MUL_X;
            S_MUL_X: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_ACC;
            S_ACC:   n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_steps == STEP_W'(1)) ? S_IDLE : S_FOLD;
                end
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_stall        = (r_state != S_IDLE);
        o_valid        = r_out_valid;
        o_cfg_ready    = 1'b1;
        o_cmd.op       = OP_NONE;
        o_cmd.iter_idx = ATAN_IDX_W'(r_iter);
        o_cmd.last     = (r_steps == STEP_W'(1));
        unique case (r_state)
            S_IDLE:  if (i_valid) o_cmd.op = OP_LOAD;
            S_PREP:  o_cmd.op = OP_PREP;
            S_FOLD:  o_cmd.op = OP_FOLD;
            S_ITER:  o_cmd.op = OP_ITER;
            S_MUL_X: o_cmd.op = OP_MUL_X;
            S_MUL_Y: o_cmd.op = OP_MUL_Y;
            S_ACC:   o_cmd.op = OP_ACC;
            S_EMIT:  if (out_free) o_cmd.op = OP_EMIT;
        endcase
    end

    // Counters and output valid.
    always_comb begin
        n_iter      = r_iter;
        n_steps     = r_steps;
        n_out_valid = r_out_valid;
        if (r_state == S_FOLD) begin
            n_iter = '0;
        end else if (r_state == S_ITER) begin
            n_iter = r_iter + IW'(1);
        end
        if (accept) begin
            n_steps = hor_eff + STEP_W'(1);
        end else if (emit) begin
            n_steps = r_steps - STEP_W'(1);
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
            r_def_hor   <= DEF_HOR_RESET;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_def_hor <= (i_cfg_data == '0) ? HOR_W'(1) : i_cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/unicycle_trajectory_rollout.sv
// ----------------------------------------------------------------------------
// Unicycle trajectory rollout
// Rolls one motion candidate forward by Euler steps of 0.1 s from the local
// origin and streams out the predicted points.
// ----------------------------------------------------------------------------
// Each input transaction is one candidate (speed, turn rate, horizon); it
// produces horizon+1 output transactions, one per Euler step, with the final
// point flagged by last_point. A zero horizon uses the default register, and
// the horizon is capped at MAX_HORIZON_TICKS and at 63. The sine and
// cosine of each point come from a single CORDIC stage that performs one
// rotation per cycle, followed by one shared multiplier used for x and then
// y. A downstream stall keeps a finished point in the output register, and
// the block busy with its candidate, until the point is taken. The block
// takes one candidate at a time; o_stall rises once a candidate is accepted
// and falls after its last point is handed to the output register, so the
// next candidate is accepted while that last point still waits to be taken.
// ----------------------------------------------------------------------------
module unicycle_trajectory_rollout
    import ucr_pkg::*;
#(
    parameter int MAX_HORIZON_TICKS = 63,
    parameter int TRIG_ITERATIONS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Candidate input channel.
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_data,
    // Trajectory point output channel.
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data,
    // Default horizon register write channel.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [HOR_W-1:0] i_cfg_data
);

    // Command bus from the controller to the datapath.
    t_dp_cmd cmd;

    // The controller owns all handshakes, the step and iteration counters and
    // the default horizon; it tells the datapath what to do each cycle.
    ucr_ctrl #(
        .MAX_HORIZON_TICKS (MAX_HORIZON_TICKS),
        .TRIG_ITERATIONS   (TRIG_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_horizon   (i_data.horizon_ticks),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd)
    );

    // The datapath holds the pose, the CORDIC rotator, the position
    // multiplier and the output payload register.
    ucr_dp u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_data (i_data),
        .o_data (o_data)
    );

    // A candidate is loaded only on an accepted input transaction.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_LOAD |-> i_valid && !o_stall)
        else $error("datapath loaded without an accepted input transaction");

    // A new point never overwrites a point that is still waiting.
    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT |-> !o_valid || !i_stall)
        else $error("output point overwritten while stalled");

    // An emitted point shows up on the output in the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT |=> o_valid)
        else $error("emitted point not presented");

    // After the last point the block is ready for the next candidate.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT && cmd.last |=> !o_stall && o_data.last_point)
        else $error("block still busy after the last point");

endmodule

>>> bench/ucr_trajectory_checker.sv
// ----------------------------------------------------------------------------
// Unicycle trajectory rollout checker
// Watches the candidate, point and register channels, rolls every accepted
// candidate forward with its own fixed-point model and compares each point.
// ----------------------------------------------------------------------------
module ucr_trajectory_checker
    import ucr_pkg::*;
#(
    parameter int MAX_HORIZON_TICKS = 63,
    parameter int TRIG_ITERATIONS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cand_valid,
    input  logic             i_cand_stall,
    input  t_in_item         i_cand,
    input  logic             i_point_valid,
    input  logic             i_point_stall,
    input  t_out_item        i_point,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [HOR_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_points_pending
);

    localparam int REPORT_LIMIT = 10;

    longint           arctan_lut [ATAN_ENTRIES];
    t_out_item        expected_points [$];
    t_out_item        want;
    logic [HOR_W-1:0] default_horizon = DEF_HOR_RESET;
    int               fail_count = 0;

    // Arctangent of 2^-i as a binary angle, one full turn = 2^32.
    initial begin
        arctan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331,
                       21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                       333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                       1304, 652, 326, 163, 81};
    end

    // Rotation-mode CORDIC in Q2.30. Headings in the back half-plane are
    // turned by half a circle first and the results negated afterwards.
    function automatic void cordic_cos_sin(input logic [31:0] heading,
                                           output longint cos_q30,
                                           output longint sin_q30);
        logic        back_half;
        logic [31:0] folded;
        longint      resid, vx, vy, vx_sh, vy_sh;
        back_half = (heading[31:30] == 2'b01) || (heading[31:30] == 2'b10);
        folded    = back_half ? heading + 32'h8000_0000 : heading;
        resid     = longint'(signed'(folded));
        vx        = longint'(CORDIC_X0);
        vy        = 0;
        for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_ENTRIES; i++) begin
            vx_sh = vx >>> i;
            vy_sh = vy >>> i;
            if (resid >= 0) begin
                vx    = vx - vy_sh;
                vy    = vy + vx_sh;
                resid = resid - arctan_lut[i];
            end else begin
                vx    = vx + vy_sh;
                vy    = vy - vx_sh;
                resid = resid + arctan_lut[i];
            end
        end
        cos_q30 = back_half ? -vx : vx;
        sin_q30 = back_half ? -vy : vy;
    endfunction

    // Speed (Q8.8) times a unit vector component (Q30) times dt (Q20),
    // rounded half up into Q16.16.
    function automatic logic [31:0] position_delta(input longint speed,
                                                   input longint trig_q30);
        longint prod, shifted;
        prod    = speed * trig_q30 * longint'(DT_Q20) + (longint'(1) << 41);
        shifted = prod >>> 42;
        return shifted[31:0];
    endfunction

    // Euler rollout of one candidate from the origin; queues every point.
    function automatic void roll_out_candidate(input t_in_item cand);
        int          horizon, n_points;
        longint      speed, turn, head_prod, cos_q30, sin_q30;
        logic [31:0] x_acc, y_acc, heading, head_step;
        t_out_item   pt;
        horizon = (cand.horizon_ticks == '0) ? int'(default_horizon)
                                             : int'(cand.horizon_ticks);
        if (horizon > MAX_HORIZON_TICKS) horizon = MAX_HORIZON_TICKS;
        if (horizon > HOR_LIMIT) horizon = HOR_LIMIT;
        n_points  = horizon + 1;
        speed     = cand.linear_speed;
        turn      = cand.turn_rate;
        head_prod = turn * longint'(HEAD_K) + 64'sd32768;
        head_step = head_prod[47:16];
        x_acc     = '0;
        y_acc     = '0;
        heading   = '0;
        for (int k = 0; k < n_points; k++) begin
            cordic_cos_sin(heading, cos_q30, sin_q30);
            x_acc         = x_acc + position_delta(speed, cos_q30);
            y_acc         = y_acc + position_delta(speed, sin_q30);
            heading       = heading + head_step;
            pt.x_pos      = x_acc;
            pt.y_pos      = y_acc;
            pt.last_point = (k == n_points - 1);
            expected_points = {expected_points, pt};
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            default_horizon = DEF_HOR_RESET;
            expected_points.delete();
        end else begin
            // Points are retired before a new candidate is queued, so a last
            // point leaving at the same edge still meets its own expectation.
            if (i_point_valid && !i_point_stall) begin
                if (expected_points.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected point: x=%0d y=%0d last=%0b",
                                 i_point.x_pos, i_point.y_pos, i_point.last_point);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (i_point.x_pos !== want.x_pos || i_point.y_pos !== want.y_pos ||
                        i_point.last_point !== want.last_point) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                     want.x_pos, want.y_pos, want.last_point,
                                     i_point.x_pos, i_point.y_pos, i_point.last_point);
                        end
                    end
                end
            end
            if (i_cand_valid && !i_cand_stall) begin
                roll_out_candidate(i_cand);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                default_horizon = (i_cfg_data == '0) ? HOR_W'(1) : i_cfg_data;
            end
        end
        o_fail_count     <= fail_count;
        o_points_pending <= expected_points.size();
    end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Unicycle trajectory rollout testbench
// Drives directed and random motion candidates and default-horizon writes
// into the rollout block under changing idle and stall patterns; a checker
// beside the block predicts every trajectory point and compares it.
// ----------------------------------------------------------------------------
module testbench;
    import ucr_pkg::*;

    localparam int MAX_HOR      = 63;
    localparam int TRIG_ITERS   = 16;
    // Cycles without any accepted transaction before the run is abandoned.
    // This is far beyond the longest legitimate quiet stretch, even with heavy
    // stalling.
    localparam int QUIET_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int SETTLE_CYCLES   = 50;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cand_valid;
    logic             cand_stall;
    t_in_item         cand_data;
    logic             point_valid;
    logic             point_stall;
    t_out_item        point_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [HOR_W-1:0] cfg_data;

    int fail_count;
    int points_pending;
    int sender_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    unicycle_trajectory_rollout #(
        .MAX_HORIZON_TICKS (MAX_HOR),
        .TRIG_ITERATIONS   (TRIG_ITERS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (cand_valid),
        .o_stall     (cand_stall),
        .i_data      (cand_data),
        .o_valid     (point_valid),
        .i_stall     (point_stall),
        .o_data      (point_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ucr_trajectory_checker #(
        .MAX_HORIZON_TICKS (MAX_HOR),
        .TRIG_ITERATIONS   (TRIG_ITERS)
    ) trajectory_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cand_valid     (cand_valid),
        .i_cand_stall     (cand_stall),
        .i_cand           (cand_data),
        .i_point_valid    (point_valid),
        .i_point_stall    (point_stall),
        .i_point          (point_data),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending)
    );

    // The point consumer stalls on its own schedule, independent of whether
    // a point is being offered.
    always @(posedge clk) begin
        point_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Any accepted transaction on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (cand_valid && !cand_stall) || (point_valid && !point_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("unicycle_trajectory_rollout verification failed");
            $finish;
        end
    end

    function automatic t_in_item make_candidate(input logic [15:0] speed,
                                                input logic [15:0] turn,
                                                input logic [5:0]  horizon);
        t_in_item cand;
        cand.linear_speed  = speed;
        cand.turn_rate     = turn;
        cand.horizon_ticks = horizon;
        return cand;
    endfunction

    // A 16-bit field value: sometimes an extreme, often a moderate value
    // such as a planner would try, otherwise anything at all.
    function automatic logic [15:0] random_word();
        logic [15:0] word;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(3))
                0:       word = 16'h8000;
                1:       word = 16'h7fff;
                2:       word = 16'hffff;
                default: word = 16'h0000;
            endcase
        end else if (pick < 55) begin
            word = 16'($urandom_range(4095)) - 16'd2048;
        end else begin
            word = 16'($urandom);
        end
        return word;
    endfunction

    // Horizons are mostly short to keep the run quick; a few run to the
    // limit. Zero selects the default register.
    function automatic t_in_item random_candidate();
        int          pick;
        logic [5:0]  horizon;
        pick = $urandom_range(99);
        if (pick < 70) begin
            horizon = 6'($urandom_range(8));
        end else if (pick < 90) begin
            horizon = 6'($urandom_range(62, 9));
        end else begin
            horizon = 6'd63;
        end
        return make_candidate(random_word(), random_word(), horizon);
    endfunction

    // Offers one candidate and returns at the edge that accepts it. Idle
    // cycles come first, so valid is never dropped while a transaction is
    // still being offered.
    task automatic push_candidate(input t_in_item cand);
        while ($urandom_range(99) < sender_idle_pct) begin
            cand_valid <= 1'b0;
            @(posedge clk);
        end
        cand_valid <= 1'b1;
        cand_data  <= cand;
        @(posedge clk);
        while (cand_stall) @(posedge clk);
    endtask

    // Stops offering candidates and waits until every predicted point has
    // been taken. The first edge lets the pending count catch up with the
    // candidate accepted just before.
    task automatic wait_for_drain();
        cand_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0) @(posedge clk);
    endtask

    task automatic write_default_horizon(input logic [HOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in_item         directed [$];
        logic [HOR_W-1:0] hor_setting;

        rst_n           <= 1'b0;
        cand_valid      <= 1'b0;
        cand_data       <= '0;
        cfg_valid       <= 1'b0;
        cfg_data        <= '0;
        sender_idle_pct <= 0;
        recv_stall_pct  <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed candidates, run against the reset default of 20 ticks:
        // standing still, straight runs at full forward and reverse speed,
        // full-rate turns over the longest horizon so that the heading
        // sweeps every quadrant, zero horizons, tiny values and
        // alternating bit patterns.
        directed = {directed, make_candidate(16'h0000, 16'h0000, 6'd1)};
        directed = {directed, make_candidate(16'h7fff, 16'h0000, 6'd63)};
        directed = {directed, make_candidate(16'h8000, 16'h0000, 6'd5)};
        directed = {directed, make_candidate(16'h7fff, 16'h7fff, 6'd63)};
        directed = {directed, make_candidate(16'h8000, 16'h8000, 6'd63)};
        directed = {directed, make_candidate(16'h0100, 16'h1000, 6'd0)};
        directed = {directed, make_candidate(16'hffff, 16'hffff, 6'd2)};
        directed = {directed, make_candidate(16'h0001, 16'h0001, 6'd1)};
        directed = {directed, make_candidate(16'h5555, 16'haaaa, 6'h2a)};
        directed = {directed, make_candidate(16'haaaa, 16'h5555, 6'h15)};
        directed = {directed, make_candidate(16'h7fff, 16'h8000, 6'd0)};
        directed = {directed, make_candidate(16'h8000, 16'h7fff, 6'd3)};
        directed = {directed, make_candidate(16'h0000, 16'h7fff, 6'd10)};
        directed = {directed, make_candidate(16'h0a00, 16'h1922, 6'd40)};
        foreach (directed[i]) begin
            push_candidate(directed[i]);
        end

        // Random phases, each starting with a default-horizon write and with its own
        // mix of sender gaps and consumer stalls. The register is only written
        // once the block has delivered every point.
        for (int phase = 0; phase < 4; phase++) begin
            wait_for_drain();
            case (phase)
                0:       hor_setting = 6'd63;
                1:       hor_setting = 6'd0;
                2:       hor_setting = 6'($urandom_range(62, 2));
                default: hor_setting = 6'd1;
            endcase
            write_default_horizon(hor_setting);
            sender_idle_pct <= (phase == 1) ? 49 : (phase == 3) ? 13 : 0;
            recv_stall_pct  <= (phase == 2) ? 49 : (phase == 3) ? 13 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through, hold off until the block runs dry.
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_for_drain();
                end
                push_candidate(random_candidate());
            end
        end

        // Let every point come out, then leave room for anything extra.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && points_pending == 0) begin
            $display("unicycle_trajectory_rollout verification clean");
        end else begin
            $display("unicycle_trajectory_rollout verification failed");
        end
        $finish;
    end

endmodule
